@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the edge weight block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GCN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("edge weight block assertion failed");

`define GCN_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("edge weight block reset assertion failed");

`else

`define GCN_ASSERT(lbl, prop)
`define GCN_ASSERT_RST(lbl, prop)

`endif

`endif

@@ hw/rtl/gcnew_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcnew_pkg
// Shared sizes, register indexes and constants of the edge weight block.
// ----------------------------------------------------------------------------
package gcnew_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W  = CNT_W + 1;
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned HDIM_W = ROW_W + 1;
  localparam int unsigned POS_W  = ROW_W + DIM_W + 1;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NODE_W     = 20;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FAC_W      = 16;
  localparam int unsigned SIG_W      = 24;
  localparam int unsigned REG_DIM_W  = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned N_TERMS = 12;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [47:0] EXP_LIMIT = 48'(LN2_Q32) << 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH     = 3'd0,
    CFG_HEIGHT    = 3'd1,
    CFG_EIGHT_WAY = 3'd2,
    CFG_AXIAL     = 3'd3,
    CFG_DIAGONAL  = 3'd4,
    CFG_INV_SIGMA = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
  } fac_rd_t;

  // Clamps a frame dimension register to 1..lim.
  function automatic logic [REG_DIM_W-1:0] clamp_dim(logic [REG_DIM_W-1:0] v,
                                                     int unsigned lim);
    logic [REG_DIM_W-1:0] res;
    if (v == '0) begin
      res = REG_DIM_W'(1);
    end else if (int'(v) > int'(lim)) begin
      res = REG_DIM_W'(lim);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Floor of 2^32 / n for the series divisors.
  function automatic logic [31:0] div_recip(logic [3:0] n);
    logic [31:0] res;
    case (n)
      4'd2:    res = 32'd2147483648;
      4'd3:    res = 32'd1431655765;
      4'd4:    res = 32'd1073741824;
      4'd5:    res = 32'd858993459;
      4'd6:    res = 32'd715827882;
      4'd7:    res = 32'd613566756;
      4'd8:    res = 32'd536870912;
      4'd9:    res = 32'd477218588;
      4'd10:   res = 32'd429496729;
      4'd11:   res = 32'd390451572;
      4'd12:   res = 32'd357913941;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/gcnew_ftab.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// gcnew_ftab
// Gaussian factor table: one Q0.16 entry per intensity difference, rebuilt
// by an iterative exponent unit after reset and after each sigma write.
// ----------------------------------------------------------------------------
module gcnew_ftab
  import gcnew_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rebuild_i,
  input  logic [SIG_W-1:0] inv_sigma_i,
  input  fac_rd_t          rd_i,
  output logic [FAC_W-1:0] rd_data_o,
  output logic             busy_o
);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_SQ   = 8'b0000_0010,
    F_X    = 8'b0000_0100,
    F_DIV  = 8'b0000_1000,
    F_T1   = 8'b0001_0000,
    F_T2   = 8'b0010_0000,
    F_T3   = 8'b0100_0000,
    F_FIN  = 8'b1000_0000
  } fst_e;

  fst_e             st_q, st_d;
  logic [PIX_W-1:0] entry_q, entry_d;
  logic [2:0]       j_q, j_d;
  logic [3:0]       n_q, n_d;

  logic [15:0] d2_q;
  logic [47:0] x_q;
  logic [4:0]  k_q;
  logic [31:0] r_q;
  logic [31:0] term_q;
  logic [32:0] sum_q;
  logic [31:0] t_q;
  logic [31:0] pm_q;

  logic [FAC_W-1:0] fac_mem [2**PIX_W];
  logic [FAC_W-1:0] rd_data_q;

  logic [39:0]      x_prod;
  logic [47:0]      step_val;
  logic             step_ge;
  logic [47:0]      x_sub;
  logic [63:0]      tr_prod;
  logic [63:0]      rc_prod;
  logic [9:0]       qn;
  logic [5:0]       rem6;
  logic [31:0]      q_corr;
  logic [5:0]       shamt;
  logic [47:0]      f48;
  logic             ovf;
  logic             fac_we;
  logic [FAC_W-1:0] fac_wdata;
  logic             last_entry;

  always_comb begin
    x_prod   = 40'(d2_q) * 40'(inv_sigma_i);
    step_val = 48'(LN2_Q32) << j_q;
    step_ge  = x_q >= step_val;
    x_sub    = step_ge ? x_q - step_val : x_q;
    ovf      = (j_q == 3'd4) && (x_q >= EXP_LIMIT);
    tr_prod  = 64'(term_q) * 64'(r_q);
    rc_prod  = 64'(t_q) * 64'(div_recip(n_q));
    qn       = 10'(pm_q[5:0]) * 10'(n_q);
    rem6     = t_q[5:0] - qn[5:0];
    q_corr   = pm_q + 32'(rem6 >= 6'(n_q));
    shamt    = 6'd16 + 6'(k_q);
    f48      = (48'(sum_q) + (48'd1 << (shamt - 6'd1))) >> shamt;
  end

  always_comb begin
    fac_we    = 1'b0;
    fac_wdata = '0;
    if (st_q == F_DIV && ovf) begin
      fac_we = 1'b1;
    end else if (st_q == F_FIN) begin
      fac_we    = 1'b1;
      fac_wdata = (|f48[47:16]) ? '1 : f48[15:0];
    end
  end

  assign last_entry = entry_q == '1;

  always_comb begin
    st_d    = st_q;
    entry_d = entry_q;
    j_d     = j_q;
    n_d     = n_q;
    case (st_q)
      F_IDLE: st_d = F_IDLE;
      F_SQ:   st_d = F_X;
      F_X: begin
        st_d = F_DIV;
        j_d  = 3'd4;
      end
      F_DIV: begin
        if (ovf) begin
          st_d    = last_entry ? F_IDLE : F_SQ;
          entry_d = entry_q + 1'b1;
        end else if (j_q == 3'd0) begin
          st_d = F_T1;
          n_d  = 4'd2;
        end else begin
          j_d = j_q - 3'd1;
        end
      end
      F_T1: st_d = F_T2;
      F_T2: st_d = F_T3;
      F_T3: begin
        if (n_q == 4'(N_TERMS)) begin
          st_d = F_FIN;
        end else begin
          st_d = F_T1;
          n_d  = n_q + 4'd1;
        end
      end
      F_FIN: begin
        st_d    = last_entry ? F_IDLE : F_SQ;
        entry_d = entry_q + 1'b1;
      end
      default: st_d = F_IDLE;
    endcase
    if (rebuild_i) begin
      st_d    = F_SQ;
      entry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_SQ;
      entry_q <= '0;
      j_q     <= '0;
      n_q     <= 4'd2;
    end else begin
      st_q    <= st_d;
      entry_q <= entry_d;
      j_q     <= j_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      F_SQ: d2_q <= 16'(entry_q) * 16'(entry_q);
      F_X: begin
        x_q <= {x_prod, 8'd0};
        k_q <= '0;
      end
      F_DIV: begin
        x_q <= x_sub;
        if (step_ge) begin
          k_q[j_q] <= 1'b1;
        end
        r_q    <= x_sub[31:0];
        term_q <= x_sub[31:0];
        sum_q  <= 33'h1_0000_0000 - 33'(x_sub[31:0]);
      end
      F_T1: t_q  <= tr_prod[63:32];
      F_T2: pm_q <= rc_prod[63:32];
      F_T3: begin
        term_q <= q_corr;
        sum_q  <= n_q[0] ? sum_q - 33'(q_corr) : sum_q + 33'(q_corr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fac_we) begin
      fac_mem[entry_q] <= fac_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= fac_mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = st_q != F_IDLE;

  `GCN_ASSERT(a_term_index, st_q == F_T1 |-> (n_q >= 4'd2 && n_q <= 4'(N_TERMS)))
  `GCN_ASSERT(a_corr_bound, st_q == F_T3 |-> rem6 < 6'(n_q) * 6'd2)
  `GCN_ASSERT(a_restart, rebuild_i |=> (st_q == F_SQ && entry_q == '0))

endmodule

@@ hw/rtl/graph_cut_neighbor_edge_weights.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// graph_cut_neighbor_edge_weights
// Emits Gaussian boundary edge records to the earlier 4- or 8-neighbors of
// each raster-order grey pixel, using a previous-row store and a factor table.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// s_axis   in   tdata[7:0] intensity, tuser frame_start
// m_axis   out  tdata node_a, node_b, edge_weight; tlast last_edge
// cfg      in   write enable, register index, write data
//
// A pixel passes the accept (ST_IDLE) and row-store read (ST_RDUR) states, then per edge
// record, up to four, a factor table read (ST_LOOK) and an output register load (ST_WGT);
// with no edge it returns from ST_LOOK to ST_IDLE. After reset and after each inv_sigma_w
// write the factor table is rebuilt, and s_axis_tready stays low meanwhile.
// The last record of a pixel waits in the output register while the next pixel
// is taken in; a stalled m_axis holds the record and the sequencer.
// ----------------------------------------------------------------------------
module graph_cut_neighbor_edge_weights
  import gcnew_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] intensity
  input  logic                  s_axis_tuser,  // [0] frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // [19:0] node_a, [39:20] node_b,
                                               // [55:40] edge_weight
  output logic                  m_axis_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RDUR = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_WGT  = 4'b1000
  } st_e;

  logic [REG_DIM_W-1:0] width_q, height_q;
  logic                 eight_q;
  logic [GAIN_W-1:0]    axial_q, diag_q;
  logic [SIG_W-1:0]     inv_q;
  logic                 rebuild;

  st_e              st_q;
  logic [CNT_W-1:0] col_cnt_q;
  logic [ROW_W-1:0] row_cnt_q;
  logic [PIX_W-1:0] prev_q, abl_q;
  logic [3:0]       mask_q;
  logic             out_valid_q;

  logic [PIX_W-1:0]  cur_q, nb_left_q, nb_ul_q, up_q;
  logic [CNT_W-1:0]  col_q;
  logic [DIM_W-1:0]  w_q;
  logic [NODE_W-1:0] here_q, above_q;
  logic [3:0]        sel_q;
  logic [NODE_W-1:0] node_a_q, node_b_q;
  logic [GAIN_W-1:0] weight_q;
  logic              last_q;

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rs_rdata_q;
  logic             rs_re;
  logic [CNT_W-1:0] rs_raddr;

  fac_rd_t          fac_rd;
  logic [FAC_W-1:0] fac_rdata;
  logic             fac_busy;

  logic [DIM_W-1:0]  w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic [CNT_W-1:0]  c0, col_e, col_cnt_d;
  logic [ROW_W-1:0]  r0, row_e, row_cnt_d;
  logic [HDIM_W-1:0] r1, rn;
  logic [DIM_W-1:0]  cn;
  logic              wrap_c, col_end;
  logic [POS_W-1:0]  here_full;
  logic [3:0]        mask_d;
  logic              accept;

  logic [3:0]        sel_d;
  logic [PIX_W-1:0]  nb;
  logic [PIX_W-1:0]  diff;
  logic [GAIN_W-1:0] gain;
  logic [32:0]       wsum;
  logic [NODE_W-1:0] node_b_d;
  logic [3:0]        mask_left;
  logic              out_free;

  assign rebuild = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_INV_SIGMA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_DIM_W'(1024);
      height_q <= REG_DIM_W'(1024);
      eight_q  <= 1'b0;
      axial_q  <= GAIN_W'(4096);
      diag_q   <= GAIN_W'(4096);
      inv_q    <= SIG_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:     width_q  <= cfg_data_i[REG_DIM_W-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[REG_DIM_W-1:0];
        CFG_EIGHT_WAY: eight_q  <= cfg_data_i[0];
        CFG_AXIAL:     axial_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DIAGONAL:  diag_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_INV_SIGMA: inv_q    <= cfg_data_i[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  gcnew_ftab u_ftab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rebuild_i   (rebuild),
    .inv_sigma_i (inv_q),
    .rd_i        (fac_rd),
    .rd_data_o   (fac_rdata),
    .busy_o      (fac_busy)
  );

  assign s_axis_tready = (st_q == ST_IDLE) && !fac_busy && !rebuild;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    w_eff     = DIM_W'(clamp_dim(width_q, MAX_WIDTH));
    h_eff     = HDIM_W'(clamp_dim(height_q, MAX_HEIGHT));
    c0        = s_axis_tuser ? '0 : col_cnt_q;
    r0        = s_axis_tuser ? '0 : row_cnt_q;
    wrap_c    = DIM_W'(c0) >= w_eff;
    col_e     = wrap_c ? '0 : c0;
    r1        = wrap_c ? HDIM_W'(r0) + 1'b1 : HDIM_W'(r0);
    row_e     = (r1 >= h_eff) ? '0 : ROW_W'(r1);
    cn        = DIM_W'(col_e) + 1'b1;
    col_end   = cn >= w_eff;
    rn        = HDIM_W'(row_e) + 1'b1;
    col_cnt_d = col_end ? '0 : CNT_W'(cn);
    row_cnt_d = col_end ? ((rn >= h_eff) ? '0 : ROW_W'(rn)) : row_e;
    here_full = POS_W'(row_e) * POS_W'(w_eff) + POS_W'(col_e);
    mask_d[0] = col_e != '0;
    mask_d[2] = row_e != '0;
    mask_d[1] = mask_d[2] && eight_q && mask_d[0];
    mask_d[3] = mask_d[2] && eight_q && !col_end;
  end

  always_comb begin
    sel_d = mask_q & (~mask_q + 4'd1);
    if (mask_q[0]) begin
      nb = nb_left_q;
    end else if (mask_q[1]) begin
      nb = nb_ul_q;
    end else if (mask_q[2]) begin
      nb = up_q;
    end else begin
      nb = rs_rdata_q;
    end
    diff        = (cur_q > nb) ? cur_q - nb : nb - cur_q;
    fac_rd.en   = (st_q == ST_LOOK) && (mask_q != '0);
    fac_rd.addr = diff;
  end

  always_comb begin
    gain      = (sel_q[1] || sel_q[3]) ? diag_q : axial_q;
    wsum      = 33'(32'(gain) * 32'(fac_rdata)) + 33'd32768;
    mask_left = mask_q & ~sel_q;
    out_free  = !out_valid_q || m_axis_tready;
    if (sel_q[0]) begin
      node_b_d = here_q - 1'b1;
    end else if (sel_q[1]) begin
      node_b_d = above_q - 1'b1;
    end else if (sel_q[2]) begin
      node_b_d = above_q;
    end else begin
      node_b_d = above_q + 1'b1;
    end
  end

  always_comb begin
    rs_re    = 1'b0;
    rs_raddr = col_e;
    if (accept) begin
      rs_re = 1'b1;
    end else if (st_q == ST_RDUR) begin
      rs_re    = 1'b1;
      rs_raddr = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_re) begin
      rs_rdata_q <= row_mem[rs_raddr];
    end
    if (st_q == ST_RDUR) begin
      row_mem[col_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      prev_q      <= '0;
      abl_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == ST_WGT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            st_q      <= ST_RDUR;
            col_cnt_q <= col_cnt_d;
            row_cnt_q <= row_cnt_d;
            prev_q    <= s_axis_tdata;
            mask_q    <= mask_d;
          end
        end
        ST_RDUR: begin
          st_q  <= ST_LOOK;
          abl_q <= rs_rdata_q;
        end
        ST_LOOK: begin
          st_q <= (mask_q == '0) ? ST_IDLE : ST_WGT;
        end
        ST_WGT: begin
          if (out_free) begin
            mask_q <= mask_left;
            st_q   <= (mask_left == '0) ? ST_IDLE : ST_LOOK;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q     <= s_axis_tdata;
      col_q     <= col_e;
      w_q       <= w_eff;
      here_q    <= NODE_W'(here_full);
      nb_left_q <= prev_q;
      nb_ul_q   <= abl_q;
    end
    if (st_q == ST_RDUR) begin
      up_q    <= rs_rdata_q;
      above_q <= here_q - NODE_W'(w_q);
    end
    if (st_q == ST_LOOK) begin
      sel_q <= sel_d;
    end
    if (st_q == ST_WGT && out_free) begin
      node_a_q <= here_q;
      node_b_q <= node_b_d;
      weight_q <= wsum[31:16];
      last_q   <= mask_left == '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {weight_q, node_b_q, node_a_q};
  assign m_axis_tlast  = last_q;

  `GCN_ASSERT(a_accept_needs_table, s_axis_tready |-> !fac_busy)
  `GCN_ASSERT(a_accept_to_read, (s_axis_tvalid && s_axis_tready) |=> st_q == ST_RDUR)
  `GCN_ASSERT(a_wgt_onehot, st_q == ST_WGT |-> $onehot(sel_q))
  `GCN_ASSERT(a_diag_with_up, mask_q[1] |-> mask_q[2])
  `GCN_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule
